>>> hdl/sfpa_pkg.sv
// ----------------------------------------------------------------------------
// Signed fixed-point ALU package
// Shared types and constants for the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package sfpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_MIN    = 4'd4,
    OP_MAX    = 4'd5,
    OP_INC    = 4'd6,
    OP_DEC    = 4'd7,
    OP_TO_INT = 4'd8
  } op_e;

  // How the back end has to treat a queued transaction.
  typedef enum logic [1:0] {
    CLS_DONE,
    CLS_MUL,
    CLS_DIV
  } class_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_ROUND
  } back_state_e;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic signed [31:0] FxMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FxMin = 32'sh8000_0000;

  typedef struct packed {
    class_e             cls;
    logic signed [31:0] value;
    logic               ovf;
    logic               dz;
    logic               eq;
    logic               lt;
    logic               gt;
    logic               neg;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
  } entry_t;

endpackage

>>> hdl/sfpa_front.sv
// ----------------------------------------------------------------------------
// Signed fixed-point ALU front end
// Classifies each transaction, finishes every operation but multiply and
// non-zero divide, and prepares magnitudes and sign for multiply and divide.
// ----------------------------------------------------------------------------
module sfpa_front #(
  parameter int FRACTION_BITS = 8
) (
  input  logic [3:0]          mode_i,
  input  logic signed [31:0]  operand_a_i,
  input  logic signed [31:0]  operand_b_i,
  output sfpa_pkg::entry_t    entry_o
);
  import sfpa_pkg::*;

  logic signed [32:0] sum;
  logic signed [32:0] diff;
  logic signed [32:0] incr;
  logic signed [32:0] decr;
  logic               a_neg;
  logic               b_neg;

  function automatic logic signed [31:0] clamp(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? FxMin : FxMax;
    end
    return v[31:0];
  endfunction

  assign sum   = 33'(operand_a_i) + 33'(operand_b_i);
  assign diff  = 33'(operand_a_i) - 33'(operand_b_i);
  assign incr  = 33'(operand_a_i) + 33'sd1;
  assign decr  = 33'(operand_a_i) - 33'sd1;
  assign a_neg = operand_a_i[31];
  assign b_neg = operand_b_i[31];

  always_comb begin
    entry_o       = '0;
    entry_o.cls   = CLS_DONE;
    entry_o.eq    = operand_a_i == operand_b_i;
    entry_o.lt    = operand_a_i < operand_b_i;
    entry_o.gt    = operand_a_i > operand_b_i;
    entry_o.neg   = a_neg ^ b_neg;
    entry_o.mag_a = a_neg ? 32'(-operand_a_i) : 32'(operand_a_i);
    entry_o.mag_b = b_neg ? 32'(-operand_b_i) : 32'(operand_b_i);
    unique case (mode_i)
      OP_ADD: begin
        entry_o.value = clamp(sum);
        entry_o.ovf   = sum[32] != sum[31];
      end
      OP_SUB: begin
        entry_o.value = clamp(diff);
        entry_o.ovf   = diff[32] != diff[31];
      end
      OP_MUL: entry_o.cls = CLS_MUL;
      OP_DIV: begin
        if (operand_b_i == '0) begin
          // Division by zero saturates by the sign of the dividend; a zero dividend gives zero.
          entry_o.dz    = 1'b1;
          entry_o.value = a_neg ? FxMin : ((operand_a_i == '0) ? '0 : FxMax);
        end else begin
          entry_o.cls = CLS_DIV;
        end
      end
      OP_MIN: entry_o.value = (operand_a_i <= operand_b_i) ? operand_a_i : operand_b_i;
      OP_MAX: entry_o.value = (operand_a_i >= operand_b_i) ? operand_a_i : operand_b_i;
      OP_INC: begin
        entry_o.value = clamp(incr);
        entry_o.ovf   = incr[32] != incr[31];
      end
      OP_DEC: begin
        entry_o.value = clamp(decr);
        entry_o.ovf   = decr[32] != decr[31];
      end
      OP_TO_INT: entry_o.value = operand_a_i >>> FRACTION_BITS;
      default: entry_o.value = '0;
    endcase
  end

endmodule

>>> hdl/sfpa_queue.sv
// ----------------------------------------------------------------------------
// Signed fixed-point ALU queue
// Small FIFO of classified transactions between front end and back end.
// ----------------------------------------------------------------------------
module sfpa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfpa_pkg::entry_t  push_data_i,
  input  logic              pop_i,
  output sfpa_pkg::entry_t  pop_data_o,
  output logic              full_o,
  output logic              empty_o
);
  import sfpa_pkg::*;

  entry_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign full_o     = count_q == QCntW'(QueueDepth);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hdl/sfpa_back.sv
// ----------------------------------------------------------------------------
// Signed fixed-point ALU back end
// Multiplier with a registered product, bit-serial restoring divider, rounding, saturation
// and the registered result strobe.
// ----------------------------------------------------------------------------
module sfpa_back #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfpa_pkg::entry_t   entry_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               result_valid_o,
  output logic signed [31:0] value_out_o,
  output logic               is_equal_o,
  output logic               is_less_o,
  output logic               is_greater_o,
  output logic               overflowed_o,
  output logic               divided_by_zero_o
);
  import sfpa_pkg::*;

  localparam int Nw   = 32 + FRACTION_BITS;
  localparam int CntW = $clog2(Nw + 1);
  localparam logic [63:0] Half = (64'd1 << FRACTION_BITS) >> 1;

  typedef struct packed {
    logic signed [31:0] value;
    logic               ovf;
  } sat_t;

  back_state_e     state_q, state_d;
  entry_t          ent_q, ent_d;
  logic [63:0]     prod_q, prod_d;
  logic [31:0]     rem_q, rem_d;
  logic [Nw-1:0]   num_q, num_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            valid_q, valid_d;
  entry_t          res_q, res_d;

  logic [32:0]     rem_shift;
  logic            rem_ge;
  logic            round_up;
  sat_t            mul_res;
  sat_t            div_res;

  // Applies the sign to an unsigned magnitude and saturates to 32 bits.
  function automatic sat_t saturate(input logic [63:0] mag, input logic neg);
    sat_t r;
    r.ovf   = 1'b0;
    r.value = '0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.ovf   = 1'b1;
        r.value = FxMin;
      end else begin
        r.value = 32'(-mag);
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r.ovf   = 1'b1;
        r.value = FxMax;
      end else begin
        r.value = mag[31:0];
      end
    end
    return r;
  endfunction

  assign rem_shift = {rem_q, num_q[Nw-1]};
  assign rem_ge    = rem_shift >= {1'b0, ent_q.mag_b};
  assign round_up  = {rem_q, 1'b0} >= {1'b0, ent_q.mag_b};
  assign mul_res   = saturate((prod_q + Half) >> FRACTION_BITS, ent_q.neg);
  assign div_res   = saturate(64'(num_q) + 64'(round_up), ent_q.neg);

  always_comb begin
    state_d = state_q;
    ent_d   = ent_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    num_d   = num_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    res_d   = res_q;
    pop_o   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          ent_d = entry_i;
          unique case (entry_i.cls)
            CLS_MUL: begin
              prod_d  = 64'(entry_i.mag_a) * 64'(entry_i.mag_b);
              state_d = BK_MUL;
            end
            CLS_DIV: begin
              rem_d   = '0;
              num_d   = Nw'(entry_i.mag_a) << FRACTION_BITS;
              cnt_d   = '0;
              state_d = BK_DIV;
            end
            default: begin
              valid_d = 1'b1;
              res_d   = entry_i;
            end
          endcase
        end
      end
      BK_MUL: begin
        valid_d     = 1'b1;
        res_d       = ent_q;
        res_d.value = mul_res.value;
        res_d.ovf   = mul_res.ovf;
        state_d     = BK_IDLE;
      end
      BK_DIV: begin
        rem_d = rem_ge ? 32'(rem_shift - {1'b0, ent_q.mag_b}) : rem_shift[31:0];
        num_d = {num_q[Nw-2:0], rem_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(Nw - 1)) begin
          state_d = BK_ROUND;
        end
      end
      BK_ROUND: begin
        valid_d     = 1'b1;
        res_d       = ent_q;
        res_d.value = div_res.value;
        res_d.ovf   = div_res.ovf;
        state_d     = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    res_q  <= res_d;
  end

  assign result_valid_o    = valid_q;
  assign value_out_o       = res_q.value;
  assign is_equal_o        = res_q.eq;
  assign is_less_o         = res_q.lt;
  assign is_greater_o      = res_q.gt;
  assign overflowed_o      = res_q.ovf;
  assign divided_by_zero_o = res_q.dz;

endmodule

>>> hdl/signed_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Signed fixed-point ALU
// Add, subtract, multiply, divide, min, max, increment, decrement and integer
// conversion on 32-bit signed fixed-point words, with compare flags.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low; each result
// appears for one cycle with result_valid_o and cannot be held off, and
// results come out in the order the transactions were taken. Up to four
// transactions wait in a queue, so busy_o rises only when it is full. All
// operations except multiply and divide by a non-zero divisor leave in the
// cycle after they reach the back end and follow one per cycle while the
// queue holds them. Multiply occupies the back end for product and rounding.
// Divide runs a bit-serial restoring divider and occupies the back end for
// set-up, one step per quotient bit, then rounding.
module signed_fixed_point_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [3:0]         mode_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               result_valid_o,
  output logic signed [31:0] value_out_o,
  output logic               is_equal_o,
  output logic               is_less_o,
  output logic               is_greater_o,
  output logic               overflowed_o,
  output logic               divided_by_zero_o
);
  import sfpa_pkg::*;

  entry_t front_entry;
  entry_t queue_entry;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  assign busy_o = q_full;

  sfpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .mode_i      (mode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .entry_o     (front_entry)
  );

  sfpa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start_i && !q_full),
    .push_data_i (front_entry),
    .pop_i       (q_pop),
    .pop_data_o  (queue_entry),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  sfpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .entry_i           (queue_entry),
    .empty_i           (q_empty),
    .pop_o             (q_pop),
    .result_valid_o    (result_valid_o),
    .value_out_o       (value_out_o),
    .is_equal_o        (is_equal_o),
    .is_less_o         (is_less_o),
    .is_greater_o      (is_greater_o),
    .overflowed_o      (overflowed_o),
    .divided_by_zero_o (divided_by_zero_o)
  );

`ifndef SYNTHESIS
  a_dz_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && divided_by_zero_o |-> !overflowed_o)
    else $error("division by zero also flagged overflow");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $onehot({is_equal_o, is_less_o, is_greater_o}))
    else $error("compare flags not exactly one");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end took a transaction from an empty queue");
`endif

endmodule
